>>> src/rpn_pkg.sv
// package for the rpn stack evaluator: codes, state type and defaults
package rpn_pkg;

  localparam int unsigned StackDepth = 64;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned AluWidth  = DataWidth + 2;

  // token op codes
  localparam logic [2:0] OpClear = 3'd0;
  localparam logic [2:0] OpPush  = 3'd1;
  localparam logic [2:0] OpAdd   = 3'd2;
  localparam logic [2:0] OpSub   = 3'd3;
  localparam logic [2:0] OpMul   = 3'd4;
  localparam logic [2:0] OpDiv   = 3'd5;

  // result status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StUnknown   = 3'd1;
  localparam logic [2:0] StUnderflow = 3'd2;
  localparam logic [2:0] StDivZero   = 3'd3;
  localparam logic [2:0] StFull      = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_NEG_A,
    S_NEG_B,
    S_DIV,
    S_NEG_Q,
    S_MUL,
    S_WRITE,
    S_TOP,
    S_DONE
  } state_e;

endpackage

>>> src/rpn_stack_integer_evaluator.sv
// reverse polish integer evaluator over a bounded stack, with one shared adder
//
// input channel: in_valid_i / in_stall_o with op_i and push_value_i. a token is
// taken only while the block is idle; in_stall_o stays high until its result
// has been moved into the output register.
// output channel: out_valid_o / out_stall_i with status_o, top_value_o,
// is_empty_o and depth_o, one result per token, held while stalled. the next
// token can be taken while a result still waits in the output register.
// steps per token:
//   clear, push, unknown op, underflow: straight to the result step
//   add, subtract: load, write; divide by zero: load, top reload if any left
//   multiply: 32 shift-add steps
//   divide: sign fix, 32 restoring steps, quotient sign fix
// the 34-bit adder/subtractor is the only arithmetic unit; multiply and divide
// iterate one bit per cycle through it.
// the stack lives in a single-port-write memory with a registered read port;
// the top entry is mirrored in a register.
// reset clears the entry count and the output valid; stack contents need no
// clearing, since only entries below the count are ever read.
// a stalled result blocks only the token after it at its final step.
module rpn_stack_integer_evaluator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = rpn_pkg::StackDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] top_value_o,
  output logic               is_empty_o,
  output logic [6:0]         depth_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  state_e state_q, state_d;

  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q, out_valid_d;

  logic [DataWidth-1:0]   a_q, a_d;
  logic [DataWidth-1:0]   b_q, b_d;
  logic [DataWidth-1:0]   acc_q, acc_d;
  logic [DataWidth-1:0]   tos_q, tos_d;
  logic [4:0]             iter_q, iter_d;
  logic                   neg_q, neg_d;
  logic [2:0]             op_q, op_d;
  logic [2:0]             status_q, status_d;

  logic [2:0]             out_status_q;
  logic [DataWidth-1:0]   out_top_q;
  logic                   out_empty_q;
  logic [6:0]             out_depth_q;
  logic                   out_load;

  // stack memory
  logic [DataWidth-1:0]   mem_q [STACK_DEPTH];
  logic [DataWidth-1:0]   mem_rdata_q;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [DataWidth-1:0]   mem_wdata;

  // shared adder/subtractor
  logic [AluWidth-1:0]    alu_x, alu_y, alu_sum;
  logic                   alu_sub;

  assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + AluWidth'(alu_sub);

  assign in_stall_o = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i >= OpAdd && op_i <= OpDiv && count_q >= CW'(2)) begin
            state_d = S_LOAD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_LOAD: begin
        unique case (op_q) inside
          OpAdd, OpSub: state_d = S_WRITE;
          OpMul:        state_d = S_MUL;
          default: begin
            if (b_q == '0) begin
              state_d = (count_q > CW'(2)) ? S_TOP : S_DONE;
            end else begin
              state_d = S_NEG_A;
            end
          end
        endcase
      end
      S_NEG_A: state_d = S_NEG_B;
      S_NEG_B: state_d = S_DIV;
      S_DIV:   state_d = (iter_q == '1) ? S_NEG_Q : S_DIV;
      S_NEG_Q: state_d = S_WRITE;
      S_MUL:   state_d = (iter_q == '1) ? S_WRITE : S_MUL;
      S_WRITE: state_d = S_DONE;
      S_TOP:   state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    count_d   = count_q;
    a_d       = a_q;
    b_d       = b_q;
    acc_d     = acc_q;
    tos_d     = tos_q;
    iter_d    = iter_q;
    neg_d     = neg_q;
    op_d      = op_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(count_q);
    mem_raddr = AW'(count_q - CW'(2));
    mem_wdata = acc_q;
    alu_x     = '0;
    alu_y     = '0;
    alu_sub   = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_i;
          status_d = StOk;
          case (op_i) inside
            OpClear: count_d = '0;
            OpPush: begin
              if (count_q == CW'(STACK_DEPTH)) begin
                status_d = StFull;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_q);
                mem_wdata = push_value_i;
                tos_d     = push_value_i;
                count_d   = count_q + CW'(1);
              end
            end
            OpAdd, OpSub, OpMul, OpDiv: begin
              if (count_q < CW'(2)) begin
                status_d = StUnderflow;
              end else begin
                // fetch the second entry; the top one is already in tos_q
                mem_re    = 1'b1;
                mem_raddr = AW'(count_q - CW'(2));
                b_d       = tos_q;
              end
            end
            default: status_d = StUnknown;
          endcase
        end
      end
      S_LOAD: begin
        a_d   = mem_rdata_q;
        neg_d = mem_rdata_q[DataWidth-1] ^ b_q[DataWidth-1];
        case (op_q) inside
          OpAdd, OpSub: begin
            alu_x   = AluWidth'(mem_rdata_q);
            alu_y   = AluWidth'(b_q);
            alu_sub = (op_q == OpSub);
            acc_d   = alu_sum[DataWidth-1:0];
          end
          OpMul: begin
            acc_d  = '0;
            iter_d = '0;
          end
          default: begin
            if (b_q == '0) begin
              // both operands dropped; any new top comes back from memory
              status_d = StDivZero;
              count_d  = count_q - CW'(2);
              if (count_q > CW'(2)) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(count_q - CW'(3));
              end
            end else begin
              acc_d  = '0;
              iter_d = '0;
            end
          end
        endcase
      end
      S_NEG_A: begin
        alu_y   = AluWidth'(a_q);
        alu_sub = 1'b1;
        if (a_q[DataWidth-1]) begin
          a_d = alu_sum[DataWidth-1:0];
        end
      end
      S_NEG_B: begin
        alu_y   = AluWidth'(b_q);
        alu_sub = 1'b1;
        if (b_q[DataWidth-1]) begin
          b_d = alu_sum[DataWidth-1:0];
        end
      end
      S_DIV: begin
        // restoring step: remainder in acc_q, dividend shifts out of a_q
        alu_x   = {1'b0, acc_q, a_q[DataWidth-1]};
        alu_y   = AluWidth'(b_q);
        alu_sub = 1'b1;
        if (!alu_sum[AluWidth-1]) begin
          acc_d = alu_sum[DataWidth-1:0];
          a_d   = {a_q[DataWidth-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[DataWidth-2:0], a_q[DataWidth-1]};
          a_d   = {a_q[DataWidth-2:0], 1'b0};
        end
        iter_d = iter_q + 5'd1;
      end
      S_NEG_Q: begin
        alu_y   = AluWidth'(a_q);
        alu_sub = 1'b1;
        acc_d   = neg_q ? alu_sum[DataWidth-1:0] : a_q;
      end
      S_MUL: begin
        // shift-add, only the low word of the product is kept
        alu_x  = AluWidth'(acc_q);
        alu_y  = b_q[0] ? AluWidth'(a_q) : '0;
        acc_d  = alu_sum[DataWidth-1:0];
        a_d    = {a_q[DataWidth-2:0], 1'b0};
        b_d    = {1'b0, b_q[DataWidth-1:1]};
        iter_d = iter_q + 5'd1;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(count_q - CW'(2));
        mem_wdata = acc_q;
        tos_d     = acc_q;
        count_d   = count_q - CW'(1);
      end
      S_TOP: tos_d = mem_rdata_q;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    tos_q    <= tos_d;
    iter_q   <= iter_d;
    neg_q    <= neg_d;
    op_q     <= op_d;
    status_q <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_top_q    <= (count_q == '0) ? '0 : tos_q;
      out_empty_q  <= (count_q == '0);
      out_depth_q  <= 7'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign top_value_o = out_top_q;
  assign is_empty_o  = out_empty_q;
  assign depth_o     = out_depth_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the done step");

  a_transfer_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("token transfer did not start work");

  a_write_below_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> count_d != '0)
    else $error("stack write leaves the stack empty");
`endif

endmodule

>>> tb/sv/rpn_stack_integer_evaluator_test.sv
// testbench for the rpn stack integer evaluator: directed and random token streams
`timescale 1ns / 100ps

module rpn_stack_integer_evaluator_test
  import rpn_pkg::*;
();

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] top_value;
    logic               is_empty;
    logic [6:0]         depth;
  } stack_result_t;

  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;
  localparam logic [2:0] OpUnknownLo = 3'd6;
  localparam logic [2:0] OpUnknownHi = 3'd7;
  localparam int unsigned StackAw = $clog2(StackDepth);

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         op_i = OpClear;
  logic signed [31:0] push_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic signed [31:0] top_value_o;
  logic               is_empty_o;
  logic [6:0]         depth_o;

  rpn_stack_integer_evaluator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .top_value_o  (top_value_o),
    .is_empty_o   (is_empty_o),
    .depth_o      (depth_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the stack
  logic signed [31:0] model_stack [StackDepth];
  int unsigned        model_depth = 0;
  stack_result_t      pending_results [$];
  int                 mismatches = 0;
  int                 burst_left = 1;

  function automatic stack_result_t evaluate_token(input logic [2:0] op,
                                                   input logic signed [31:0] value);
    stack_result_t      res;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] r;
    res.status = StOk;
    r = '0;
    case (op) inside
      OpClear: model_depth = 0;
      OpPush: begin
        if (model_depth >= StackDepth) begin
          res.status = StFull;
        end else begin
          model_stack[StackAw'(model_depth)] = value;
          model_depth++;
        end
      end
      OpAdd, OpSub, OpMul, OpDiv: begin
        if (model_depth < 2) begin
          res.status = StUnderflow;
        end else begin
          b = model_stack[StackAw'(model_depth - 1)];
          a = model_stack[StackAw'(model_depth - 2)];
          model_depth -= 2;
          case (op)
            OpAdd: r = a + b;
            OpSub: r = a - b;
            OpMul: r = a * b;
            default: begin
              if (b == 0) res.status = StDivZero;
              else if (a == IntMin && b == -32'sd1) r = IntMin;
              else r = a / b;
            end
          endcase
          // divide by zero pushes nothing back
          if (res.status == StOk) begin
            model_stack[StackAw'(model_depth)] = r;
            model_depth++;
          end
        end
      end
      default: res.status = StUnknown;
    endcase
    res.is_empty = (model_depth == 0);
    res.top_value = res.is_empty ? 32'sd0 : model_stack[StackAw'(model_depth - 1)];
    res.depth = 7'(model_depth);
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return IntMin;
      1: return IntMax;
      2: return 32'($urandom_range(0, 2)) - 32'sd1;
      3: return 32'sh1 << $urandom_range(0, 31);
      4: return -(32'sh1 << $urandom_range(0, 31));
      5, 6: return 32'($urandom_range(0, 32)) - 32'sd16;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_token(input logic [2:0] op, input logic signed [31:0] value);
    in_valid_i <= 1'b1;
    op_i <= op;
    push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(evaluate_token(op, value));
    burst_left--;
    if (burst_left <= 0) begin
      // idle gap with junk on the payload
      in_valid_i <= 1'b0;
      op_i <= 3'($urandom);
      push_value_i <= $urandom;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 32);
    end
  endtask

  // receiver stall, switching between calm, light, heavy and long-run patterns
  int   stall_mode = 0;
  int   stall_mode_left = 0;
  int   stall_run = 0;
  logic stall_level = 1'b0;

  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(50, 400);
    end
    stall_mode_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run == 0) begin
          stall_level = !stall_level;
          stall_run = $urandom_range(1, 20);
        end
        stall_run--;
        out_stall_i <= stall_level;
      end
    endcase
  end

  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (top_value_o !== want.top_value)
          report_mismatch("top_value", top_value_o, want.top_value);
        if (is_empty_o !== want.is_empty)
          report_mismatch("is_empty", 32'(is_empty_o), 32'(want.is_empty));
        if (depth_o !== want.depth)
          report_mismatch("depth", 32'(depth_o), 32'(want.depth));
      end
    end
  end

  task automatic test_directed_ops();
    send_token(OpAdd, IntMax);         // underflow on empty stack
    send_token(OpPush, IntMax);
    send_token(OpSub, '0);             // underflow with one entry
    send_token(OpPush, 32'sd1);
    send_token(OpAdd, '0);             // wraps to most negative
    send_token(OpPush, -32'sd1);
    send_token(OpDiv, '0);             // most negative over minus one
    send_token(OpPush, 32'sd2);
    send_token(OpMul, '0);             // wraps to zero
    send_token(OpPush, '0);
    send_token(OpDiv, '0);             // divide by zero drops both operands
    send_token(OpPush, IntMin);
    send_token(OpPush, 32'sd1);
    send_token(OpSub, '0);             // wraps to most positive
    send_token(OpPush, -32'sd7);
    send_token(OpDiv, 32'shffff_ffff); // truncates toward zero
    send_token(OpPush, -32'sd3);
    send_token(OpMul, '0);
    send_token(OpUnknownLo, IntMin);
    send_token(OpUnknownHi, 32'shffff_ffff);
    send_token(OpPush, 32'shffff_ffff);
    send_token(OpClear, IntMax);
    send_token(OpClear, '0);           // clear on empty
    send_token(OpDiv, '0);
  endtask

  task automatic test_random_programs(input int n_tokens);
    int         max_depth;
    int         pick;
    logic [2:0] op;
    max_depth = $urandom_range(2, 6);
    repeat (n_tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        op = OpClear;
        max_depth = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(2, 6);
      end else if (pick < 5) begin
        op = $urandom_range(0, 1) ? OpUnknownLo : OpUnknownHi;
      end else if (pick < 9) begin
        op = 3'($urandom);
      end else if (model_depth < 2 || (model_depth < max_depth && pick[0])) begin
        op = OpPush;
      end else begin
        op = 3'($urandom_range(OpAdd, OpDiv));
      end
      send_token(op, pick_value());
    end
  endtask

  task automatic test_stack_full();
    send_token(OpClear, pick_value());
    repeat (StackDepth) send_token(OpPush, pick_value());
    repeat (2) send_token(OpPush, pick_value());
    // fold the full stack back down
    while (model_depth > 1) send_token(3'($urandom_range(OpAdd, OpDiv)), pick_value());
  endtask

  task automatic test_restart_after_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    burst_left = 16;
    test_random_programs(16);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_random_programs(500);
    test_restart_after_drain();
    test_stack_full();
    test_random_programs(500);
    test_restart_after_drain();
    test_stack_full();
    test_random_programs(100);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("rpn_stack_integer_evaluator_test OK");
    end else begin
      $display("rpn_stack_integer_evaluator_test NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("rpn_stack_integer_evaluator_test NOT OK");
    $finish;
  end

endmodule
